// File: rtl/core/plt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_pkg
// Shared types and constants of the clamped piecewise linear table.
// ----------------------------------------------------------------------------
package plt_pkg;

   localparam int MAX_POINTS = 64;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int DATA_W     = 32;
   localparam int PC_W       = 7;
   localparam int IDX_W      = 6;
   localparam int CSR_IDX_W  = 1;

   // iterative multiply/divide unit
   localparam int MDU_W     = DATA_W + 1;
   localparam int MDU_STEPS = MDU_W;
   localparam int MDU_CNT_W = $clog2(MDU_STEPS);

   localparam logic [CSR_IDX_W-1:0] CSR_START_OFFSET = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT  = 1'd1;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic [1:0] REGION_LOW  = 2'd0;
   localparam logic [1:0] REGION_MID  = 2'd1;
   localparam logic [1:0] REGION_HIGH = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_FIRST,
      ST_CHK_FIRST,
      ST_RD_LAST,
      ST_CHK_LAST,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_RD_LOW,
      ST_CAP_LOW,
      ST_SETUP,
      ST_MULDIV,
      ST_FINISH
   } seq_state_type;

   typedef enum logic [1:0] {
      MDU_IDLE,
      MDU_MUL,
      MDU_DIV,
      MDU_DONE
   } mdu_state_type;

   typedef struct packed {
      logic             start;
      logic [MDU_W-1:0] mag;
      logic [MDU_W-1:0] delta;
      logic [MDU_W-1:0] span;
   } mdu_cmd_type;

   typedef struct packed {
      logic             done;
      logic [MDU_W-1:0] quot;
   } mdu_rsp_type;

endpackage

// File: rtl/core/plt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module plt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/plt_mdu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_mdu
// Shared add/subtract unit stepped as a shift-add multiplier and then as a
// restoring divider, giving floor(mag * delta / span), one bit per cycle.
// ----------------------------------------------------------------------------
module plt_mdu (
   input  logic                clock,
   input  logic                reset,
   input  plt_pkg::mdu_cmd_type cmd,
   output plt_pkg::mdu_rsp_type rsp
);
   import plt_pkg::*;

   mdu_state_type state_ff, state_in;

   logic [MDU_W-1:0]     mag_ff, mag_in;
   logic [MDU_W-1:0]     span_ff, span_in;
   logic [2*MDU_W-1:0]   acc_ff, acc_in;
   logic [MDU_CNT_W-1:0] cnt_ff, cnt_in;

   logic [MDU_W:0]   op_a;
   logic [MDU_W:0]   op_b;
   logic             op_cin;
   logic [MDU_W+1:0] sum;
   logic             last_step;
   logic             ge;
   logic [MDU_W-1:0] rem_new;

   // shared adder
   always_comb begin
      if (state_ff == MDU_DIV) begin
         op_a   = acc_ff[2*MDU_W-1:MDU_W-1];
         op_b   = ~{1'b0, span_ff};
         op_cin = 1'b1;
      end else begin
         op_a   = {1'b0, acc_ff[2*MDU_W-1:MDU_W]};
         op_b   = acc_ff[0] ? {1'b0, mag_ff} : '0;
         op_cin = 1'b0;
      end
      sum = {1'b0, op_a} + {1'b0, op_b} + {{(MDU_W+1){1'b0}}, op_cin};
   end

   assign last_step = (cnt_ff == MDU_CNT_W'(MDU_STEPS - 1));
   assign ge        = sum[MDU_W+1];
   assign rem_new   = ge ? sum[MDU_W-1:0] : op_a[MDU_W-1:0];

   // next state
   always_comb begin
      case (state_ff)
         MDU_IDLE: state_in = cmd.start ? MDU_MUL : MDU_IDLE;
         MDU_MUL:  state_in = last_step ? MDU_DIV : MDU_MUL;
         MDU_DIV:  state_in = last_step ? MDU_DONE : MDU_DIV;
         MDU_DONE: state_in = MDU_IDLE;
         default:  state_in = MDU_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      mag_in  = mag_ff;
      span_in = span_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      case (state_ff)
         MDU_IDLE: begin
            if (cmd.start) begin
               mag_in  = cmd.mag;
               span_in = cmd.span;
               acc_in  = {{MDU_W{1'b0}}, cmd.delta};
               cnt_in  = '0;
            end
         end
         MDU_MUL: begin
            acc_in = {sum[MDU_W:0], acc_ff[MDU_W-1:1]};
            cnt_in = last_step ? '0 : cnt_ff + 1'b1;
         end
         MDU_DIV: begin
            acc_in = {rem_new, acc_ff[MDU_W-2:0], ge};
            cnt_in = last_step ? '0 : cnt_ff + 1'b1;
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MDU_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff  <= mag_in;
      span_ff <= span_in;
      acc_ff  <= acc_in;
      cnt_ff  <= cnt_in;
   end

   // outputs
   always_comb begin
      rsp.done = (state_ff == MDU_DONE);
      rsp.quot = acc_ff[MDU_W-1:0];
   end

endmodule

// File: rtl/core/plt_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_seq
// Query sequencer: clamps against the end knots, walks the table for the
// enclosing segment and drives the multiply/divide unit.
// ----------------------------------------------------------------------------
module plt_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         query_go,
   input  logic [plt_pkg::DATA_W-1:0]   query_time,
   input  logic [plt_pkg::DATA_W-1:0]   start_offset,
   input  logic [plt_pkg::PC_W-1:0]     point_count,
   output logic [plt_pkg::ADDR_W-1:0]   rd_addr,
   input  logic [plt_pkg::DATA_W-1:0]   t_rdata,
   input  logic [plt_pkg::DATA_W-1:0]   v_rdata,
   output plt_pkg::mdu_cmd_type          mdu_cmd,
   input  plt_pkg::mdu_rsp_type          mdu_rsp,
   output logic                         busy,
   output logic                         rsp_valid,
   output logic [plt_pkg::DATA_W-1:0]   rsp_amplitude,
   output logic [1:0]                   rsp_region
);
   import plt_pkg::*;

   seq_state_type state_ff, state_in;

   logic signed [DATA_W:0]   s_ff, s_in;
   logic [ADDR_W-1:0]        last_ff, last_in;
   logic [ADDR_W-1:0]        j_ff, j_in;
   logic [DATA_W-1:0]        t0_ff, t0_in, v0_ff, v0_in;
   logic [DATA_W-1:0]        t1_ff, t1_in, v1_ff, v1_in;
   logic                     neg_ff, neg_in;
   logic [DATA_W-1:0]        res_ff, res_in;
   logic [1:0]               region_ff, region_in;

   logic signed [DATA_W:0]   t_rd_ext;
   logic                     s_le_t;
   logic                     s_lt_t;
   logic signed [DATA_W:0]   w;
   logic signed [DATA_W+1:0] d;
   logic signed [DATA_W:0]   dv;
   logic [MDU_W-1:0]         d_clamp;
   logic [MDU_W-1:0]         mag;
   logic                     w_bad;
   logic [DATA_W-1:0]        q32;

   assign t_rd_ext = $signed({t_rdata[DATA_W-1], t_rdata});
   assign s_le_t   = (s_ff <= t_rd_ext);
   assign s_lt_t   = (s_ff < t_rd_ext);

   // segment arithmetic
   always_comb begin
      w  = $signed({t1_ff[DATA_W-1], t1_ff}) - $signed({t0_ff[DATA_W-1], t0_ff});
      d  = $signed({s_ff[DATA_W], s_ff}) - $signed({{2{t0_ff[DATA_W-1]}}, t0_ff});
      dv = $signed({v1_ff[DATA_W-1], v1_ff}) - $signed({v0_ff[DATA_W-1], v0_ff});
      w_bad = (w <= 0);
      if (d < 0) begin
         d_clamp = '0;
      end else if (d > $signed({w[DATA_W], w})) begin
         d_clamp = w;
      end else begin
         d_clamp = d[MDU_W-1:0];
      end
      mag = dv[DATA_W] ? MDU_W'(-dv) : MDU_W'(dv);
      q32 = mdu_rsp.quot[DATA_W-1:0];
   end

   // next state
   always_comb begin
      case (state_ff)
         ST_IDLE:      state_in = query_go ? ST_RD_FIRST : ST_IDLE;
         ST_RD_FIRST:  state_in = ST_CHK_FIRST;
         ST_CHK_FIRST: state_in = s_le_t ? ST_FINISH : ST_RD_LAST;
         ST_RD_LAST:   state_in = ST_CHK_LAST;
         ST_CHK_LAST:  state_in = (s_ff >= t_rd_ext) ? ST_FINISH : ST_SCAN_RD;
         ST_SCAN_RD:   state_in = ST_SCAN_CHK;
         ST_SCAN_CHK:  state_in = (s_lt_t || j_ff == last_ff) ? ST_RD_LOW : ST_SCAN_RD;
         ST_RD_LOW:    state_in = ST_CAP_LOW;
         ST_CAP_LOW:   state_in = ST_SETUP;
         ST_SETUP:     state_in = w_bad ? ST_FINISH : ST_MULDIV;
         ST_MULDIV:    state_in = mdu_rsp.done ? ST_FINISH : ST_MULDIV;
         ST_FINISH:    state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      s_in      = s_ff;
      last_in   = last_ff;
      j_in      = j_ff;
      t0_in     = t0_ff;
      v0_in     = v0_ff;
      t1_in     = t1_ff;
      v1_in     = v1_ff;
      neg_in    = neg_ff;
      res_in    = res_ff;
      region_in = region_ff;
      case (state_ff)
         ST_IDLE: begin
            if (query_go) begin
               s_in = $signed({query_time[DATA_W-1], query_time})
                    - $signed({start_offset[DATA_W-1], start_offset});
               if (point_count == '0) begin
                  last_in = '0;
               end else if (32'(point_count) > MAX_POINTS) begin
                  last_in = ADDR_W'(MAX_POINTS - 1);
               end else begin
                  last_in = ADDR_W'(point_count - 1'b1);
               end
            end
         end
         ST_CHK_FIRST: begin
            res_in    = v_rdata;
            region_in = REGION_LOW;
         end
         ST_CHK_LAST: begin
            res_in    = v_rdata;
            region_in = REGION_HIGH;
            j_in      = ADDR_W'(1);
         end
         ST_SCAN_CHK: begin
            t1_in = t_rdata;
            v1_in = v_rdata;
            if (!(s_lt_t || j_ff == last_ff)) begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_CAP_LOW: begin
            t0_in = t_rdata;
            v0_in = v_rdata;
         end
         ST_SETUP: begin
            res_in    = v0_ff;
            region_in = REGION_MID;
            neg_in    = dv[DATA_W];
         end
         ST_MULDIV: begin
            res_in = neg_ff ? v0_ff - q32 : v0_ff + q32;
         end
         default: begin
            res_in = res_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      s_ff      <= s_in;
      last_ff   <= last_in;
      j_ff      <= j_in;
      t0_ff     <= t0_in;
      v0_ff     <= v0_in;
      t1_ff     <= t1_in;
      v1_ff     <= v1_in;
      neg_ff    <= neg_in;
      res_ff    <= res_in;
      region_ff <= region_in;
   end

   // outputs
   always_comb begin
      case (state_ff)
         ST_RD_LAST: rd_addr = last_ff;
         ST_SCAN_RD: rd_addr = j_ff;
         ST_RD_LOW:  rd_addr = j_ff - 1'b1;
         default:    rd_addr = '0;
      endcase
      mdu_cmd.start = (state_ff == ST_SETUP) && !w_bad;
      mdu_cmd.mag   = mag;
      mdu_cmd.delta = d_clamp;
      mdu_cmd.span  = w;
      busy          = (state_ff != ST_IDLE);
      rsp_valid     = (state_ff == ST_FINISH);
      rsp_amplitude = res_ff;
      rsp_region    = region_ff;
   end

endmodule

// File: rtl/core/clamped_piecewise_linear_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clamped_piecewise_linear_table
// Knot table of (time, value) pairs with clamped linear interpolation, Q16.16.
// ----------------------------------------------------------------------------
// A load request writes one knot and completes in the cycle it is taken; busy
// stays low and no response is produced. A query request holds busy high and
// produces one response strobe on rsp_valid, which the receiver must take in
// that cycle. A query clamped at the first knot answers once that knot is read
// and checked; one clamped at the last knot answers once the last knot is read
// and checked as well. An interpolated query checks both end knots, walks the
// table to the segment's upper knot, one knot at a time through the single read
// port of the knot memories, reads the lower knot and runs the multiply and then
// the divide, one bit per cycle, of the shared arithmetic unit. A segment whose
// times do not increase skips the arithmetic. Knots must be loaded before they
// are queried.
// ----------------------------------------------------------------------------
module clamped_piecewise_linear_table (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_func,
   input  logic [plt_pkg::IDX_W-1:0]      req_knot_index,
   input  logic [plt_pkg::DATA_W-1:0]     req_knot_time,
   input  logic [plt_pkg::DATA_W-1:0]     req_knot_value,
   input  logic [plt_pkg::DATA_W-1:0]     req_query_time,
   output logic                           rsp_valid,
   output logic [plt_pkg::DATA_W-1:0]     rsp_amplitude,
   output logic [1:0]                     rsp_region,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [plt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [plt_pkg::DATA_W-1:0]     csr_wdata
);
   import plt_pkg::*;

   logic [DATA_W-1:0] start_offset_ff, start_offset_in;
   logic [PC_W-1:0]   point_count_ff, point_count_in;

   logic              accept;
   logic              query_go;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [DATA_W-1:0] t_rdata;
   logic [DATA_W-1:0] v_rdata;
   mdu_cmd_type       mdu_cmd;
   mdu_rsp_type       mdu_rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      start_offset_in = start_offset_ff;
      point_count_in  = point_count_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_START_OFFSET: start_offset_in = csr_wdata;
            CSR_POINT_COUNT:  point_count_in  = csr_wdata[PC_W-1:0];
            default:          start_offset_in = start_offset_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_offset_ff <= '0;
         point_count_ff  <= PC_W'(1);
      end else begin
         start_offset_ff <= start_offset_in;
         point_count_ff  <= point_count_in;
      end
   end

   assign accept   = start && !busy;
   assign query_go = accept && (req_func == FUNC_QUERY);
   assign wr_en    = accept && (req_func == FUNC_LOAD)
                     && (32'(req_knot_index) < MAX_POINTS);
   assign wr_addr  = ADDR_W'(req_knot_index);

   plt_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_POINTS)
   ) u_time_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_knot_time),
      .rd_addr (rd_addr),
      .rd_data (t_rdata)
   );

   plt_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_POINTS)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_knot_value),
      .rd_addr (rd_addr),
      .rd_data (v_rdata)
   );

   plt_mdu u_mdu (
      .clock (clock),
      .reset (reset),
      .cmd   (mdu_cmd),
      .rsp   (mdu_rsp)
   );

   plt_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .query_go      (query_go),
      .query_time    (req_query_time),
      .start_offset  (start_offset_ff),
      .point_count   (point_count_ff),
      .rd_addr       (rd_addr),
      .t_rdata       (t_rdata),
      .v_rdata       (v_rdata),
      .mdu_cmd       (mdu_cmd),
      .mdu_rsp       (mdu_rsp),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .rsp_amplitude (rsp_amplitude),
      .rsp_region    (rsp_region)
   );

endmodule

// File: tb/tb_clamped_piecewise_linear_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_clamped_piecewise_linear_table
// Self-checking testbench for the clamped piecewise linear knot table.
// ----------------------------------------------------------------------------
// Knot loads and curve queries are sent through the start/busy command port.
// The testbench keeps its own copy of the knot table and of the time origin
// and knot count registers, and predicts each query's amplitude and region.
// A monitor compares every response strobe against the oldest prediction.
// Directed requests cover reset defaults, field extremes, knots hit exactly
// and unordered knot times. Random phases then sweep register settings,
// including a zero and an oversized knot count, over ordered and unordered
// tables, with bursty request pacing.
// ----------------------------------------------------------------------------
module tb_clamped_piecewise_linear_table;
   import plt_pkg::*;

   localparam int     RANDOM_PHASES      = 12;
   localparam int     REQUESTS_PER_PHASE = 45;
   localparam int     IDLE_CYCLES        = 8;
   localparam int     END_CYCLES         = 256;
   localparam int     MAX_REPORTS        = 200;
   localparam longint TIMEOUT_NS         = 64'd20_000_000;

   typedef struct packed {
      logic [DATA_W-1:0] amplitude;
      logic [1:0]        region;
   } curve_sample_type;

   logic                 clock;
   logic                 reset          = 1'b1;
   logic                 start          = 1'b0;
   logic                 busy;
   logic                 req_func       = FUNC_LOAD;
   logic [IDX_W-1:0]     req_knot_index = '0;
   logic [DATA_W-1:0]    req_knot_time  = '0;
   logic [DATA_W-1:0]    req_knot_value = '0;
   logic [DATA_W-1:0]    req_query_time = '0;
   logic                 rsp_valid;
   logic [DATA_W-1:0]    rsp_amplitude;
   logic [1:0]           rsp_region;
   logic                 csr_valid      = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index      = CSR_START_OFFSET;
   logic [DATA_W-1:0]    csr_wdata      = '0;

   // knot table and registers as the block should hold them
   logic signed [DATA_W-1:0] knot_times  [MAX_POINTS];
   logic signed [DATA_W-1:0] knot_values [MAX_POINTS];
   logic signed [DATA_W-1:0] time_origin    = '0;
   logic [PC_W-1:0]          knot_count_reg = 7'd1;

   curve_sample_type awaited_samples[$];

   int error_count     = 0;
   int load_count      = 0;
   int query_count     = 0;
   int csr_write_count = 0;
   int region_hits[3]  = '{0, 0, 0};
   int burst_left      = 0;
   int gap_len         = 0;

   clamped_piecewise_linear_table dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_knot_index (req_knot_index),
      .req_knot_time  (req_knot_time),
      .req_knot_value (req_knot_value),
      .req_query_time (req_query_time),
      .rsp_valid      (rsp_valid),
      .rsp_amplitude  (rsp_amplitude),
      .rsp_region     (rsp_region),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int active_points();
      if (knot_count_reg == 0) return 1;
      if (knot_count_reg > MAX_POINTS) return MAX_POINTS;
      return int'(knot_count_reg);
   endfunction

   function automatic curve_sample_type interpolate_curve(input logic [DATA_W-1:0] qt);
      curve_sample_type   r;
      int                 n;
      int                 seg;
      longint             s, t0, t1, v0, v1, w, d, dv, y;
      longint unsigned    mag, quo;
      n = active_points();
      s = longint'(signed'(qt)) - longint'(time_origin);
      if (s <= longint'(knot_times[0])) begin
         r.amplitude = knot_values[0];
         r.region    = REGION_LOW;
      end else if (s >= longint'(knot_times[n-1])) begin
         r.amplitude = knot_values[n-1];
         r.region    = REGION_HIGH;
      end else begin
         seg = 0;
         while (seg + 2 < n && s >= longint'(knot_times[seg+1])) seg++;
         t0 = longint'(knot_times[seg]);
         t1 = longint'(knot_times[seg+1]);
         v0 = longint'(knot_values[seg]);
         v1 = longint'(knot_values[seg+1]);
         w  = t1 - t0;
         d  = s - t0;
         dv = v1 - v0;
         if (w <= 0) begin
            y = v0;
         end else begin
            if (d < 0) d = 0;
            if (d > w) d = w;
            mag = (dv < 0) ? longint'(-dv) : longint'(dv);
            quo = (mag * longint'(d)) / longint'(w);
            y   = (dv < 0) ? v0 - longint'(quo) : v0 + longint'(quo);
         end
         r.amplitude = y[DATA_W-1:0];
         r.region    = REGION_MID;
      end
      return r;
   endfunction

   // holds the request until the block takes it, then updates the prediction
   task automatic send_request(input logic func, input logic [IDX_W-1:0] idx,
                               input logic [DATA_W-1:0] kt, input logic [DATA_W-1:0] kv,
                               input logic [DATA_W-1:0] qt);
      start          <= 1'b1;
      req_func       <= func;
      req_knot_index <= idx;
      req_knot_time  <= kt;
      req_knot_value <= kv;
      req_query_time <= qt;
      do @(posedge clock); while (busy !== 1'b0);
      if (func == FUNC_LOAD) begin
         knot_times[idx]  = kt;
         knot_values[idx] = kv;
         load_count++;
      end else begin
         awaited_samples.push_back(interpolate_curve(qt));
         query_count++;
      end
   endtask

   task automatic load_knot(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] kt,
                            input logic [DATA_W-1:0] kv);
      send_request(FUNC_LOAD, idx, kt, kv, $urandom());
   endtask

   task automatic query_curve(input logic [DATA_W-1:0] qt);
      send_request(FUNC_QUERY, 6'($urandom_range(0, 63)), $urandom(), $urandom(), qt);
   endtask

   // bursts of back-to-back requests, separated by idle gaps unless the gap drawn is zero
   task automatic pace_sender();
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      burst_left--;
      if (burst_left == 0 && gap_len > 0) begin
         start <= 1'b0;
         repeat (gap_len) @(posedge clock);
      end
   endtask

   task automatic drain_responses();
      start <= 1'b0;
      do @(posedge clock); while (awaited_samples.size() != 0);
   endtask

   task automatic wait_idle();
      drain_responses();
      while (busy !== 1'b0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [DATA_W-1:0] origin, input logic [PC_W-1:0] cnt);
      csr_valid <= 1'b1;
      csr_index <= CSR_START_OFFSET;
      csr_wdata <= origin;
      do @(posedge clock); while (csr_ready !== 1'b1);
      time_origin = origin;
      csr_index <= CSR_POINT_COUNT;
      csr_wdata <= {{(DATA_W-PC_W){1'b0}}, cnt};
      do @(posedge clock); while (csr_ready !== 1'b1);
      knot_count_reg = cnt;
      csr_valid <= 1'b0;
      csr_write_count += 2;
      @(posedge clock);
   endtask

   // ordered tables get strictly rising times at a random scale
   task automatic fill_table(input bit ordered);
      longint step_max;
      longint t;
      int     k;
      step_max = longint'(1) << $urandom_range(0, 25);
      t = longint'(signed'($urandom()));
      if (t + 64 * step_max > 64'sd2147483647) t = 64'sd2147483647 - 64 * step_max;
      for (k = 0; k < MAX_POINTS; k++) begin
         if (!ordered) begin
            t = longint'(signed'($urandom()));
            if (k > 0 && $urandom_range(0, 3) == 0) t = longint'(knot_times[k-1]);
         end
         load_knot(6'(k), t[DATA_W-1:0], $urandom());
         pace_sender();
         if (ordered) t += $urandom_range(1, 32'(step_max));
      end
   endtask

   task automatic random_query(input int n);
      logic [DATA_W-1:0] qt;
      int                k;
      int                mode;
      longint            w;
      mode = $urandom_range(0, 9);
      k    = $urandom_range(0, n - 1);
      if (mode < 2) begin
         qt = $urandom();
      end else if (mode < 4) begin
         qt = knot_times[k] + time_origin;
      end else if (mode == 9) begin
         qt = knot_times[k] + time_origin + $urandom_range(0, 6) - 32'd3;
      end else begin
         if (k == n - 1 && k > 0) k--;
         w = (k + 1 < n) ? longint'(knot_times[k+1]) - longint'(knot_times[k]) : 0;
         if (w < 0) w = 0;
         qt = knot_times[k] + time_origin + $urandom_range(0, 32'(w));
      end
      query_curve(qt);
   endtask

   task automatic test_reset_config();
      load_knot(6'd0, 32'h0001_0000, 32'h1234_5678);
      query_curve(32'h0000_0000);
      query_curve(32'h0001_0000);
      query_curve(32'h0002_0000);
   endtask

   task automatic test_segment_extremes();
      wait_idle();
      apply_settings(32'h0000_0000, 7'd4);
      load_knot(6'd0, 32'h8000_0000, 32'h7FFF_FFFF);
      load_knot(6'd1, 32'h0000_0000, 32'h8000_0000);
      load_knot(6'd2, 32'h0001_0000, 32'h0000_0000);
      load_knot(6'd3, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      query_curve(32'h8000_0000);
      query_curve(32'h8000_0001);
      query_curve(32'hC000_0000);
      query_curve(32'h0000_0000);
      query_curve(32'h0000_8000);
      query_curve(32'h0001_0000);
      query_curve(32'h7FFF_FFFE);
      query_curve(32'h7FFF_FFFF);
      // time origin at both extremes pushes the step time past 32 bits
      wait_idle();
      apply_settings(32'h8000_0000, 7'd4);
      query_curve(32'h7FFF_FFFF);
      wait_idle();
      apply_settings(32'h7FFF_FFFF, 7'd4);
      query_curve(32'h8000_0000);
   endtask

   task automatic test_unordered_knots();
      wait_idle();
      apply_settings(32'h0000_0000, 7'd5);
      load_knot(6'd0, 32'd0,   32'd100);
      load_knot(6'd1, 32'd300, -32'sd200);
      load_knot(6'd2, 32'd100, 32'd300);
      load_knot(6'd3, 32'd50,  -32'sd400);
      load_knot(6'd4, 32'd400, 32'd500);
      query_curve(32'd200);
      query_curve(32'd350);
      query_curve(32'd10);
   endtask

   task automatic test_random_curves();
      int                p, j, n;
      logic [DATA_W-1:0] origin;
      logic [PC_W-1:0]   cnt;
      for (p = 0; p < RANDOM_PHASES; p++) begin
         wait_idle();
         case (p % 6)
            0: origin = 32'h0000_0000;
            1: origin = 32'h8000_0000;
            2: origin = 32'h7FFF_FFFF;
            4: origin = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: origin = $urandom();
         endcase
         case (p)
            0: cnt = 7'd1;
            1: cnt = 7'd2;
            2: cnt = 7'd64;
            3: cnt = 7'd0;
            4: cnt = 7'd127;
            5: cnt = 7'd65;
            default: begin
               cnt = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(1, 64))
                                                 : 7'($urandom_range(2, 12));
            end
         endcase
         apply_settings(origin, cnt);
         if (p % 3 != 2) fill_table(p % 4 != 3);
         n = active_points();
         for (j = 0; j < REQUESTS_PER_PHASE; j++) begin
            if ($urandom_range(0, 11) == 0) begin
               load_knot(6'($urandom_range(0, 63)), $urandom(), $urandom());
            end else begin
               random_query(n);
            end
            pace_sender();
            if ($urandom_range(0, 40) == 0) drain_responses();
         end
      end
   endtask

   always @(posedge clock) begin : check_responses
      curve_sample_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (awaited_samples.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: unexpected response, amplitude %h region %0d",
                        $time, rsp_amplitude, rsp_region);
         end else begin
            want = awaited_samples.pop_front();
            if (rsp_amplitude !== want.amplitude) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: amplitude mismatch, expected %h actual %h",
                           $time, want.amplitude, rsp_amplitude);
            end
            if (rsp_region !== want.region) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: region mismatch, expected %0d actual %0d",
                           $time, want.region, rsp_region);
            end
            if (want.region <= REGION_HIGH) region_hits[want.region]++;
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("%0t: timeout with %0d responses outstanding", $time, awaited_samples.size());
      $display("tb_clamped_piecewise_linear_table: FAIL");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_config();
      wait_idle();
      fill_table(1'b1);
      test_segment_extremes();
      test_unordered_knots();
      test_random_curves();
      drain_responses();
      repeat (END_CYCLES) @(posedge clock);
      $display("covered %0d knot loads and %0d queries (%0d low, %0d interpolated, %0d high)",
               load_count, query_count, region_hits[0], region_hits[1], region_hits[2]);
      $display("over %0d register writes, %0d mismatches", csr_write_count, error_count);
      if (error_count == 0) begin
         $display("tb_clamped_piecewise_linear_table: PASS");
      end else begin
         $display("tb_clamped_piecewise_linear_table: FAIL");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/plt_pkg.sv
rtl/core/plt_ram.sv
rtl/core/plt_mdu.sv
rtl/core/plt_seq.sv
rtl/core/clamped_piecewise_linear_table.sv
tb/tb_clamped_piecewise_linear_table.sv
